### sv/mss_pkg.sv
// Shared types and constants of the measurement session sequencer.
`timescale 1ns / 1ps
`default_nettype none
package mss_pkg;

	localparam int unsigned ADDR_W     = 4;
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned CFG_W      = 20;
	localparam int unsigned US_W       = 30;
	localparam int unsigned TIME_W     = 64;
	localparam int unsigned ENTRY_MS_W = 32;
	localparam int unsigned PHASE_W    = 4;
	localparam int unsigned MODE_W     = 2;

	localparam int unsigned US_PER_MS = 1000;

	localparam logic [CFG_W-1:0] RST_STABLE_MS = 20'd1000;
	localparam logic [CFG_W-1:0] RST_WARMUP_MS = 20'd3000;
	localparam logic [CFG_W-1:0] RST_WINDOW_MS = 20'd30000;
	localparam logic [CFG_W-1:0] RST_HOLD_MS   = 20'd10000;

	// Divide by 1000 through reciprocal multiplication.
	// Digit step: 16-bit digits, partial dividend below 1000 * 2^16.
	localparam int unsigned DIG_W  = 16;
	localparam int unsigned DIG_N  = TIME_W / DIG_W;
	localparam int unsigned REM_W  = 10;
	localparam int unsigned DX_W   = REM_W + DIG_W;
	localparam int unsigned DIV_SH = 36;
	localparam int unsigned DIV_MW = 27;
	localparam logic [DIV_MW-1:0] DIV_M = 27'd68719477;
	// Elapsed step: dividend below 2^30, quotient below 2^21.
	localparam int unsigned EL_SH = 40;
	localparam int unsigned EL_MW = 31;
	localparam logic [EL_MW-1:0] EL_M = 31'd1099511628;

	typedef enum logic [PHASE_W-1:0] {
		PH_BOOT     = 4'd0,
		PH_SELFTEST = 4'd1,
		PH_IDLE     = 4'd2,
		PH_CWAIT    = 4'd3,
		PH_WARMUP   = 4'd4,
		PH_MEASURE  = 4'd5,
		PH_QUALITY  = 4'd6,
		PH_RESULT   = 4'd7,
		PH_ERROR    = 4'd8
	} mss_phase_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [TIME_W-1:0] now_time;
		logic              self_test_ok;
		logic              start_req;
		logic              cancel_req;
		logic              contact_ok;
		logic              leads_off;
		logic              drained;
	} mss_evt_t;

	typedef struct packed {
		logic [US_W-1:0]  stable_us;
		logic [US_W-1:0]  warm_us;
		logic [US_W-1:0]  win_us;
		logic [US_W-1:0]  hold_us;
		logic [CFG_W-1:0] warm_ms;
		logic [CFG_W-1:0] win_ms;
		logic [CFG_W-1:0] hold_ms;
	} mss_cfg_t;

	typedef struct packed {
		mss_phase_t        phase;
		logic [TIME_W-1:0] entry_time;
		logic [TIME_W-1:0] diff;
		logic [CFG_W-1:0]  dur_ms;
		logic [US_W-1:0]   dur_us;
	} mss_upd_t;

	typedef struct packed {
		logic [PHASE_W-1:0]    phase;
		logic [CFG_W-1:0]      remaining_ms;
		logic [ENTRY_MS_W-1:0] entry_ms;
	} mss_res_t;

endpackage
`default_nettype wire

### sv/mss_evt_if.sv
// Event channel: valid/ready handshake with the event fields.
`timescale 1ns / 1ps
`default_nettype none
interface mss_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [63:0] now_time;
	logic        self_test_ok;
	logic        start_req;
	logic        cancel_req;
	logic        contact_ok;
	logic        leads_off;
	logic        drained;

	modport source(output valid, mode, now_time, self_test_ok, start_req, cancel_req,
		contact_ok, leads_off, drained, input ready);
	modport sink(input valid, mode, now_time, self_test_ok, start_req, cancel_req,
		contact_ok, leads_off, drained, output ready);
endinterface
`default_nettype wire

### sv/mss_res_if.sv
// Result channel: valid/ready handshake with the result fields.
`timescale 1ns / 1ps
`default_nettype none
interface mss_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  phase;
	logic [19:0] remaining_ms;
	logic [31:0] entry_ms;

	modport source(output valid, phase, remaining_ms, entry_ms, input ready);
	modport sink(input valid, phase, remaining_ms, entry_ms, output ready);
endinterface
`default_nettype wire

### sv/mss_cfg_regs.sv
// APB register bank with the timing settings and their microsecond forms.
`timescale 1ns / 1ps
`default_nettype none
module mss_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mss_pkg::ADDR_W-1:0] paddr,
	input  logic [mss_pkg::DATA_W-1:0] pwdata,
	output logic [mss_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output mss_pkg::mss_cfg_t          cfg
);

	typedef enum logic [1:0] {
		REG_STABLE = 2'd0,
		REG_WARMUP = 2'd1,
		REG_WINDOW = 2'd2,
		REG_HOLD   = 2'd3
	} reg_idx_t;

	function automatic logic [mss_pkg::US_W-1:0] to_us(input logic [mss_pkg::CFG_W-1:0] ms);
		return mss_pkg::US_W'(ms) * mss_pkg::US_W'(mss_pkg::US_PER_MS);
	endfunction

	logic [mss_pkg::CFG_W-1:0] stable_ms_q, warm_ms_q, win_ms_q, hold_ms_q;
	logic [mss_pkg::US_W-1:0]  stable_us_q, warm_us_q, win_us_q, hold_us_q;
	logic [mss_pkg::CFG_W-1:0] wval;
	logic                      wr;
	reg_idx_t                  idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[mss_pkg::ADDR_W-1:2]);
	assign wval   = pwdata[mss_pkg::CFG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_ms_q <= mss_pkg::RST_STABLE_MS;
			warm_ms_q   <= mss_pkg::RST_WARMUP_MS;
			win_ms_q    <= mss_pkg::RST_WINDOW_MS;
			hold_ms_q   <= mss_pkg::RST_HOLD_MS;
			stable_us_q <= to_us(mss_pkg::RST_STABLE_MS);
			warm_us_q   <= to_us(mss_pkg::RST_WARMUP_MS);
			win_us_q    <= to_us(mss_pkg::RST_WINDOW_MS);
			hold_us_q   <= to_us(mss_pkg::RST_HOLD_MS);
		end else if (wr) begin
			case (idx)
				REG_STABLE: begin
					stable_ms_q <= wval;
					stable_us_q <= to_us(wval);
				end
				REG_WARMUP: begin
					warm_ms_q <= wval;
					warm_us_q <= to_us(wval);
				end
				REG_WINDOW: begin
					win_ms_q <= wval;
					win_us_q <= to_us(wval);
				end
				REG_HOLD: begin
					hold_ms_q <= wval;
					hold_us_q <= to_us(wval);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_STABLE: prdata = mss_pkg::DATA_W'(stable_ms_q);
			REG_WARMUP: prdata = mss_pkg::DATA_W'(warm_ms_q);
			REG_WINDOW: prdata = mss_pkg::DATA_W'(win_ms_q);
			REG_HOLD:   prdata = mss_pkg::DATA_W'(hold_ms_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.stable_us = stable_us_q;
	assign cfg.warm_us   = warm_us_q;
	assign cfg.win_us    = win_us_q;
	assign cfg.hold_us   = hold_us_q;
	assign cfg.warm_ms   = warm_ms_q;
	assign cfg.win_ms    = win_ms_q;
	assign cfg.hold_ms   = hold_ms_q;

endmodule
`default_nettype wire

### sv/mss_seq.sv
// Input register, session phase state and phase update logic.
`timescale 1ns / 1ps
`default_nettype none
module mss_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mss_pkg::mss_evt_t in_data,
	input  mss_pkg::mss_cfg_t cfg,
	output logic              out_valid,
	input  logic              out_ready,
	output mss_pkg::mss_upd_t out_data
);

	typedef enum logic [mss_pkg::MODE_W-1:0] {
		MODE_BEGIN   = 2'd0,
		MODE_STDONE  = 2'd1,
		MODE_UPDATE  = 2'd2,
		MODE_QUALITY = 2'd3
	} mode_t;

	logic                        v_s1, v_s2;
	mss_pkg::mss_evt_t           evt_s1;
	mss_pkg::mss_upd_t           upd_s2;
	mss_pkg::mss_phase_t         phase_q;
	logic [mss_pkg::TIME_W-1:0]  entry_q, since_q;

	logic                        rdy_s1, rdy_s2, mv1;
	logic                        good, go;
	mss_pkg::mss_phase_t         nxt;
	logic [mss_pkg::TIME_W-1:0]  now, d_entry, d_since, since_n, win_end;
	mss_pkg::mss_upd_t           upd_c;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign mv1      = v_s1 && rdy_s2;
	assign in_ready = rdy_s1;

	assign now     = evt_s1.now_time;
	assign good    = evt_s1.contact_ok && !evt_s1.leads_off;
	assign d_entry = now - entry_q;
	assign d_since = now - since_q;
	// Measuring starts at phase entry, so the entry time is the window start.
	assign win_end = entry_q + mss_pkg::TIME_W'(cfg.win_us);

	always_comb begin
		go      = 1'b0;
		nxt     = phase_q;
		since_n = since_q;
		case (mode_t'(evt_s1.mode))
			MODE_BEGIN: begin
				go  = 1'b1;
				nxt = mss_pkg::PH_SELFTEST;
			end
			MODE_STDONE: begin
				if (phase_q == mss_pkg::PH_SELFTEST) begin
					go  = 1'b1;
					nxt = evt_s1.self_test_ok ? mss_pkg::PH_IDLE : mss_pkg::PH_ERROR;
				end
			end
			MODE_UPDATE: begin
				case (phase_q)
					mss_pkg::PH_IDLE: begin
						if (evt_s1.start_req) begin
							go  = 1'b1;
							nxt = mss_pkg::PH_CWAIT;
						end
					end
					mss_pkg::PH_CWAIT: begin
						if (evt_s1.cancel_req) begin
							go  = 1'b1;
							nxt = mss_pkg::PH_IDLE;
						end else if (good) begin
							// zero since-time means no contact yet
							if (since_q == '0) begin
								since_n = now;
							end else if (d_since >= mss_pkg::TIME_W'(cfg.stable_us)) begin
								go  = 1'b1;
								nxt = mss_pkg::PH_WARMUP;
							end
						end else begin
							since_n = '0;
						end
					end
					mss_pkg::PH_WARMUP: begin
						if (evt_s1.cancel_req) begin
							go  = 1'b1;
							nxt = mss_pkg::PH_IDLE;
						end else if (!good) begin
							go  = 1'b1;
							nxt = mss_pkg::PH_CWAIT;
						end else if (d_entry >= mss_pkg::TIME_W'(cfg.warm_us)) begin
							go  = 1'b1;
							nxt = mss_pkg::PH_MEASURE;
						end
					end
					mss_pkg::PH_MEASURE: begin
						if (evt_s1.cancel_req) begin
							go  = 1'b1;
							nxt = mss_pkg::PH_IDLE;
						end else if (now >= win_end && evt_s1.drained) begin
							go  = 1'b1;
							nxt = mss_pkg::PH_QUALITY;
						end
					end
					mss_pkg::PH_RESULT: begin
						if (evt_s1.start_req) begin
							go  = 1'b1;
							nxt = mss_pkg::PH_CWAIT;
						end else if (evt_s1.cancel_req ||
							d_entry >= mss_pkg::TIME_W'(cfg.hold_us)) begin
							go  = 1'b1;
							nxt = mss_pkg::PH_IDLE;
						end
					end
					mss_pkg::PH_ERROR: begin
						if (evt_s1.start_req) begin
							go  = 1'b1;
							nxt = mss_pkg::PH_SELFTEST;
						end
					end
					default: ;
				endcase
			end
			MODE_QUALITY: begin
				if (phase_q == mss_pkg::PH_QUALITY) begin
					go  = 1'b1;
					nxt = mss_pkg::PH_RESULT;
				end
			end
			default: ;
		endcase
		if (go) begin
			since_n = '0;
		end
	end

	always_comb begin
		upd_c.phase      = nxt;
		upd_c.entry_time = go ? now : entry_q;
		upd_c.diff       = go ? '0 : d_entry;
		case (nxt)
			mss_pkg::PH_WARMUP: begin
				upd_c.dur_ms = cfg.warm_ms;
				upd_c.dur_us = cfg.warm_us;
			end
			mss_pkg::PH_MEASURE: begin
				upd_c.dur_ms = cfg.win_ms;
				upd_c.dur_us = cfg.win_us;
			end
			mss_pkg::PH_RESULT: begin
				upd_c.dur_ms = cfg.hold_ms;
				upd_c.dur_us = cfg.hold_us;
			end
			default: begin
				upd_c.dur_ms = '0;
				upd_c.dur_us = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			phase_q <= mss_pkg::PH_BOOT;
			entry_q <= '0;
			since_q <= '0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (mv1) begin
				phase_q <= nxt;
				since_q <= since_n;
				if (go) begin
					entry_q <= now;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			evt_s1 <= in_data;
		end
		if (mv1) begin
			upd_s2 <= upd_c;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = upd_s2;

endmodule
`default_nettype wire

### sv/mss_ms_conv.sv
// Millisecond conversion pipeline: remaining time and entry time divided by 1000.
`timescale 1ns / 1ps
`default_nettype none
module mss_ms_conv (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mss_pkg::mss_upd_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output mss_pkg::mss_res_t out_data
);

	localparam int unsigned NST  = 2 * mss_pkg::DIG_N;
	localparam int unsigned PW   = mss_pkg::DX_W + mss_pkg::DIV_MW;
	localparam int unsigned EPW  = mss_pkg::US_W + mss_pkg::EL_MW;

	typedef struct packed {
		mss_pkg::mss_phase_t              phase;
		logic [mss_pkg::TIME_W-1:0]       num;
		logic [mss_pkg::DX_W-1:0]         dx;
		logic [mss_pkg::DIG_W-1:0]        dq;
		logic [mss_pkg::REM_W-1:0]        rem;
		logic [mss_pkg::ENTRY_MS_W-1:0]   quot;
		logic                             expired;
		logic [mss_pkg::CFG_W-1:0]        dur_ms;
		logic [mss_pkg::CFG_W-1:0]        elapsed;
		logic [mss_pkg::CFG_W-1:0]        remaining;
	} cv_t;

	// stg_q[k] is the register after step k; odd steps close one digit
	cv_t              stg_q [NST];
	logic [NST-1:0]   vld_q;
	logic [NST-1:0]   rdy;
	cv_t              src   [NST];
	cv_t              nxt   [NST];
	logic [NST-1:0]   src_v;
	logic [EPW-1:0]   eprod;
	logic [PW-1:0]    prod  [NST];

	always_comb begin
		rdy[NST-1] = !vld_q[NST-1] || out_ready;
		for (int k = NST - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end
	assign in_ready = rdy[0];

	// Stage zero entry: elapsed ms fits 20 bits whenever the phase has not expired.
	assign eprod = EPW'(in_data.diff[mss_pkg::US_W-1:0]) * EPW'(mss_pkg::EL_M);

	always_comb begin
		src[0].phase     = in_data.phase;
		src[0].num       = in_data.entry_time;
		src[0].dx        = '0;
		src[0].dq        = '0;
		src[0].rem       = '0;
		src[0].quot      = '0;
		src[0].expired   = in_data.diff >= mss_pkg::TIME_W'(in_data.dur_us);
		src[0].dur_ms    = in_data.dur_ms;
		src[0].elapsed   = eprod[mss_pkg::EL_SH +: mss_pkg::CFG_W];
		src[0].remaining = '0;
		src_v[0]         = in_valid;
		for (int k = 1; k < NST; k++) begin
			src[k]   = stg_q[k-1];
			src_v[k] = vld_q[k-1];
		end
	end

	always_comb begin
		for (int k = 0; k < NST; k++) begin
			nxt[k]  = src[k];
			prod[k] = '0;
			if (k % 2 == 0) begin
				// bring down the next digit and estimate its quotient
				nxt[k].dx = {src[k].rem,
					src[k].num[mss_pkg::TIME_W - 1 - (k / 2) * mss_pkg::DIG_W -: mss_pkg::DIG_W]};
				prod[k]   = PW'(nxt[k].dx) * PW'(mss_pkg::DIV_M);
				nxt[k].dq = prod[k][mss_pkg::DIV_SH +: mss_pkg::DIG_W];
			end else begin
				nxt[k].rem  = mss_pkg::REM_W'(src[k].dx -
					mss_pkg::DX_W'(src[k].dq) * mss_pkg::DX_W'(mss_pkg::US_PER_MS));
				nxt[k].quot = {src[k].quot[mss_pkg::ENTRY_MS_W-mss_pkg::DIG_W-1:0], src[k].dq};
			end
			if (k == 1) begin
				nxt[k].remaining = src[k].expired ? '0 : src[k].dur_ms - src[k].elapsed;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= src_v[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NST; k++) begin
			if (rdy[k] && src_v[k]) begin
				stg_q[k] <= nxt[k];
			end
		end
	end

	assign out_valid             = vld_q[NST-1];
	assign out_data.phase        = stg_q[NST-1].phase;
	assign out_data.remaining_ms = stg_q[NST-1].remaining;
	assign out_data.entry_ms     = stg_q[NST-1].quot;

endmodule
`default_nettype wire

### sv/measurement_session_sequencer_core.sv
// Top level of the measurement session sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Measurement session sequencer. Each event transfer on evt (begin, self-test
// done, periodic update, quality evaluated, with a microsecond timestamp)
// moves the session phase machine and yields exactly one result transfer on
// res: the phase after the event, the milliseconds left in a timed phase
// (warmup, measuring, result hold; zero otherwise or once expired) and the
// phase entry time in ms truncated to 32 bits. The block takes one event per
// clock while res is not stalled; the phase update for an event is computed
// out of the input register, so back-to-back events see each other's effect.
// An event passes one input register, one phase update register, then eight
// conversion stages that divide the entry time by 1000 one 16-bit digit per
// two stages. Stages with no item still take new work while a finished
// result waits on res. Timing registers are written over APB at byte
// addresses 0, 4, 8 and 12; change them only while no event is in flight.
module measurement_session_sequencer_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mss_pkg::ADDR_W-1:0] paddr,
	input  logic [mss_pkg::DATA_W-1:0] pwdata,
	output logic [mss_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	mss_evt_if.sink                    evt,
	mss_res_if.source                  res
);

	mss_pkg::mss_cfg_t cfg;
	mss_pkg::mss_evt_t evt_data;
	mss_pkg::mss_upd_t upd;
	mss_pkg::mss_res_t res_data;
	logic              upd_valid, upd_ready;

	// Timing settings, held in ms for readback and in us for the compares.
	mss_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Gather the event fields into one payload word.
	assign evt_data.mode         = evt.mode;
	assign evt_data.now_time     = evt.now_time;
	assign evt_data.self_test_ok = evt.self_test_ok;
	assign evt_data.start_req    = evt.start_req;
	assign evt_data.cancel_req   = evt.cancel_req;
	assign evt_data.contact_ok   = evt.contact_ok;
	assign evt_data.leads_off    = evt.leads_off;
	assign evt_data.drained      = evt.drained;

	// Phase machine: evaluate every event, record entry time on change.
	mss_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (evt.valid),
		.in_ready  (evt.ready),
		.in_data   (evt_data),
		.cfg       (cfg),
		.out_valid (upd_valid),
		.out_ready (upd_ready),
		.out_data  (upd)
	);

	// Convert elapsed and entry time to milliseconds; last stage drives res.
	mss_ms_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (upd_valid),
		.in_ready  (upd_ready),
		.in_data   (upd),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_data  (res_data)
	);

	assign res.phase        = res_data.phase;
	assign res.remaining_ms = res_data.remaining_ms;
	assign res.entry_ms     = res_data.entry_ms;

endmodule
`default_nettype wire
